FILE: rtl/bole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list package
// Shared sizes, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + LEN_W + STAT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE     = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [VAL_W-1:0] t_entry;

    typedef struct packed {
        logic             accept;
        logic             wr_en;
        logic             ins;
        logic             search;
        logic [CMP_W-1:0] idx;
        logic [CMP_W-1:0] count;
        t_entry           value;
    } t_cell_ctl;

endpackage

FILE: rtl/bole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry; shifts toward or from its neighbors on insert and
// delete, and flags a key match on search.
// ----------------------------------------------------------------------------
module bole_cell import bole_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CMP_W-1:0] i_cell_idx,
    input  t_entry           i_left,
    input  t_entry           i_right,
    output t_entry           o_entry,
    output logic             o_match
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_match;
    logic   n_match;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.wr_en) begin
            if (i_ctl.ins) begin
                if (i_cell_idx == i_ctl.idx) begin
                    n_entry = i_ctl.value;
                end else if (i_cell_idx > i_ctl.idx) begin
                    n_entry = i_left;
                end
            end else if (i_cell_idx >= i_ctl.idx) begin
                n_entry = i_right;
            end
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctl.accept) begin
            n_match = i_ctl.search && (r_entry == i_ctl.value)
                      && (i_cell_idx < i_ctl.count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

FILE: rtl/bounded_ordered_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of signed values held in a chain of cells, with insert,
// delete and search operations; one result per operation.
// ----------------------------------------------------------------------------
// Stages: the cells and stage-one registers, then the output register.
// Throughput: 1 operation per cycle unless the output stalls; every cell
// shifts or compares at once; search match bits combine in the second stage.
// Reset: synchronous active low; clears the entry count and pipeline valids.
// List entries are not reset; they are written before they are read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_unit import bole_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // value, position, zero pad
    input  logic [OP_W-1:0]       i_s_axis_tuser,   // opcode
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata    // found, list_length, status
);

    logic [OP_W-1:0]  in_op;
    t_entry           in_value;
    logic [POS_W-1:0] in_pos;

    assign in_op    = i_s_axis_tuser;
    assign in_value = i_s_axis_tdata[VAL_W-1:0];
    assign in_pos   = i_s_axis_tdata[VAL_W +: POS_W];

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_s1_valid;
    logic [CNT_W-1:0]  r_s1_count;
    logic [STAT_W-1:0] r_s1_status;
    logic              r_out_valid;
    logic              r_out_found;
    logic [LEN_W-1:0]  r_out_len;
    logic [STAT_W-1:0] r_out_status;

    logic              s1_advance;
    logic              in_xfer;
    logic              is_full;
    logic              is_empty;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  del_pos;
    logic [STAT_W-1:0] status;
    t_cell_ctl         ctl;

    assign s1_advance      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign pos_x    = CMP_W'(in_pos);
    assign cnt_x    = CMP_W'(r_count);
    assign del_pos  = (pos_x == '0) ? '0 : pos_x - CMP_W'(1);

    always_comb begin
        ctl        = '0;
        ctl.accept = in_xfer;
        ctl.count  = cnt_x;
        ctl.value  = in_value;
        status     = ST_OK;
        n_count    = r_count;
        unique case (in_op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                ctl.ins = 1'b1;
                unique case (in_op)
                    OP_INS_HEAD: ctl.idx = '0;
                    OP_INS_TAIL: ctl.idx = cnt_x;
                    default:     ctl.idx = (pos_x > cnt_x) ? cnt_x : pos_x;
                endcase
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    ctl.wr_en = in_xfer;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                unique case (in_op)
                    OP_DEL_HEAD: ctl.idx = '0;
                    OP_DEL_TAIL: ctl.idx = cnt_x - CMP_W'(1);
                    default:     ctl.idx = (del_pos >= cnt_x) ? cnt_x - CMP_W'(1) : del_pos;
                endcase
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctl.wr_en = in_xfer;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_SEARCH: ctl.search = 1'b1;
            OP_NONE:   ctl.search = 1'b0;
            default:   ctl.search = 1'b0;
        endcase
    end

    t_entry               cell_entry [CAPACITY];
    logic [CAPACITY-1:0]  cell_match;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_in;
        t_entry right_in;
        if (g == 0) begin : g_first
            assign left_in = in_value;
        end else begin : g_mid_l
            assign left_in = cell_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_in = cell_entry[g];
        end else begin : g_mid_r
            assign right_in = cell_entry[g+1];
        end
        bole_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_cell_idx (CMP_W'(g)),
            .i_left     (left_in),
            .i_right    (right_in),
            .o_entry    (cell_entry[g]),
            .o_match    (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count <= n_count;
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= in_xfer;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_count  <= n_count;
            r_s1_status <= status;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_found  <= |cell_match;
            r_out_len    <= LEN_W'(r_s1_count);
            r_out_status <= r_s1_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_status, r_out_len, r_out_found});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && ctl.ins && !is_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted insert did not grow the list");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> (r_out_len == LEN_W'(CAPACITY)))
        else $error("full status without full length");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_status == ST_OK))
        else $error("found flag with error status");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine testbench
// Drives list operations over the input stream and checks each result
// against a behavioral list model or a fixed expectation: a directed table
// covering empty lists and out-of-range positions, a full list, then random
// grow/shrink sequences under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import bole_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int RAND_PER_PH = 100;
    localparam logic [VAL_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] V_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] V_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
        logic              found;
    } t_list_result;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        bit               typed;
        t_list_result     res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // value, position, zero pad
    logic [OP_W-1:0]       i_s_axis_tuser = '0;   // opcode
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // found, list_length, status

    logic [VAL_W-1:0] list_q[$];
    t_list_result     expected_q[$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_token = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  err_count = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_found = 0;
    int  n_full = 0;
    int  n_empty = 0;
    bit  grow_mode = 1'b1;

    bounded_ordered_list_engine_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] pos, output t_list_result res);
        int n;
        int idx;
        n = list_q.size();
        res = '0;
        case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    if (op == OP_INS_HEAD) idx = 0;
                    else if (op == OP_INS_TAIL) idx = n;
                    else idx = (int'(pos) > n) ? n : int'(pos);
                    list_q.insert(idx, val);
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (op == OP_DEL_HEAD) idx = 0;
                    else if (op == OP_DEL_TAIL) idx = n - 1;
                    else idx = (pos == '0) ? 0 : int'(pos) - 1;
                    if (idx >= n) idx = n - 1;
                    list_q.delete(idx);
                end
            end
            OP_SEARCH: begin
                foreach (list_q[i]) begin
                    if (list_q[i] == val) res.found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(list_q.size());
    endtask

    // Offer one operation, hold it until the transfer, then predict.
    task automatic transfer_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos, input bit typed,
                               input t_list_result typed_res);
        logic [IN_DATA_W-1:0] word;
        t_list_result         res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word = '0;
        word[VAL_W-1:0] = val;
        word[VAL_W +: POS_W] = pos;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_list_op(op, val, pos, res);
        n_items++;
        if (res.found) n_found++;
        if (res.status == ST_FULL) n_full++;
        if (res.status == ST_EMPTY) n_empty++;
        expected_q.push_back(typed ? typed_res : res);
    endtask

    task automatic pick_random_op(output logic [OP_W-1:0] op, output logic [VAL_W-1:0] val,
                                  output logic [POS_W-1:0] pos);
        int n;
        int r;
        n = list_q.size();
        if (n == CAPACITY && $urandom_range(2) != 0) grow_mode = 1'b0;
        if (n == 0 && $urandom_range(2) != 0) grow_mode = 1'b1;
        if ($urandom_range(99) < 3) grow_mode = ~grow_mode;
        r = $urandom_range(99);
        if (r < (grow_mode ? 55 : 15)) begin
            case ($urandom_range(2))
                0: op = OP_INS_HEAD;
                1: op = OP_INS_TAIL;
                default: op = OP_INS_POS;
            endcase
        end else if (r < (grow_mode ? 70 : 55)) begin
            case ($urandom_range(2))
                0: op = OP_DEL_HEAD;
                1: op = OP_DEL_TAIL;
                default: op = OP_DEL_POS;
            endcase
        end else if (r < 95) begin
            op = OP_SEARCH;
        end else begin
            op = OP_NONE;
        end
        if (op == OP_SEARCH && n != 0 && $urandom_range(1) != 0) begin
            val = list_q[$urandom_range(n - 1)];
        end else begin
            case ($urandom_range(7))
                0: val = V_MIN;
                1: val = V_MAX;
                2: val = V_NEG;
                3, 4: val = $urandom_range(7);
                default: val = $urandom;
            endcase
        end
        pos = ($urandom_range(1) != 0) ? POS_W'($urandom_range(31))
                                       : POS_W'($urandom_range(n + 1));
    endtask

    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen       <= hold_token;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.found  = o_m_axis_tdata[0];
            got.length = o_m_axis_tdata[1 +: LEN_W];
            got.status = o_m_axis_tdata[1 + LEN_W +: STAT_W];
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                want = expected_q.pop_front();
                if (got.found != want.found)
                    report_mismatch($sformatf("result %0d found %0d, want %0d",
                                              n_results, got.found, want.found));
                if (got.length != want.length)
                    report_mismatch($sformatf("result %0d length %0d, want %0d",
                                              n_results, got.length, want.length));
                if (got.status != want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              n_results, got.status, want.status));
            end
        end
    end

    initial begin
        t_stim_row        rows[$];
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        int               idle_tab[4];
        int               stall_tab[4];

        idle_tab  = '{0, 59, 0, 34};
        stall_tab = '{0, 0, 59, 34};

        rows = '{
            '{OP_DEL_HEAD, 32'd0, 5'd0,  1'b1, '{ST_EMPTY, 5'd0, 1'b0}},
            '{OP_DEL_TAIL, 32'd0, 5'd0,  1'b1, '{ST_EMPTY, 5'd0, 1'b0}},
            '{OP_DEL_POS,  32'd0, 5'd0,  1'b1, '{ST_EMPTY, 5'd0, 1'b0}},
            '{OP_DEL_POS,  V_NEG, 5'd31, 1'b1, '{ST_EMPTY, 5'd0, 1'b0}},
            '{OP_SEARCH,   32'd0, 5'd0,  1'b1, '{ST_OK,    5'd0, 1'b0}},
            '{OP_NONE,     V_MAX, 5'd16, 1'b1, '{ST_OK,    5'd0, 1'b0}},
            '{OP_INS_HEAD, V_MAX, 5'd0,  1'b1, '{ST_OK,    5'd1, 1'b0}},
            '{OP_INS_TAIL, V_MIN, 5'd31, 1'b1, '{ST_OK,    5'd2, 1'b0}},
            '{OP_INS_POS,  V_NEG, 5'd0,  1'b1, '{ST_OK,    5'd3, 1'b0}},
            '{OP_INS_POS,  32'd0, 5'd31, 1'b1, '{ST_OK,    5'd4, 1'b0}},
            '{OP_INS_POS,  32'd5, 5'd2,  1'b0, '0},
            '{OP_SEARCH,   V_MIN, 5'd0,  1'b0, '0},
            '{OP_SEARCH,   32'h7FFF_FFFE, 5'd0, 1'b0, '0},
            '{OP_NONE,     V_NEG, 5'd31, 1'b1, '{ST_OK,    5'd5, 1'b0}},
            '{OP_DEL_POS,  32'd0, 5'd0,  1'b0, '0},
            '{OP_DEL_POS,  32'd0, 5'd31, 1'b0, '0},
            '{OP_DEL_POS,  32'd0, 5'd2,  1'b0, '0},
            '{OP_SEARCH,   V_NEG, 5'd0,  1'b0, '0},
            '{OP_DEL_TAIL, 32'd0, 5'd0,  1'b0, '0},
            '{OP_DEL_HEAD, 32'd0, 5'd0,  1'b0, '0},
            '{OP_DEL_HEAD, 32'd0, 5'd0,  1'b1, '{ST_EMPTY, 5'd0, 1'b0}}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            transfer_op(rows[i].op, rows[i].value, rows[i].pos, rows[i].typed, rows[i].res);
        end

        // Fill to capacity, then try inserts that must be dropped.
        for (int i = 0; i < CAPACITY; i++) begin
            transfer_op(OP_INS_TAIL, $urandom, 5'd0, 1'b0, '0);
        end
        transfer_op(OP_INS_HEAD, V_MIN, 5'd0, 1'b1, '{ST_FULL, LEN_W'(CAPACITY), 1'b0});
        transfer_op(OP_INS_POS, V_MAX, 5'd31, 1'b1, '{ST_FULL, LEN_W'(CAPACITY), 1'b0});
        transfer_op(OP_SEARCH, list_q[CAPACITY-1], 5'd0, 1'b0, '0);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            stall_pct    <= stall_tab[ph];
            if (ph == 0) hold_token <= hold_token + 1;
            for (int k = 0; k < RAND_PER_PH; k++) begin
                pick_random_op(op, val, pos);
                transfer_op(op, val, pos, 1'b0, '0);
            end
            i_s_axis_tvalid <= 1'b0;
            while (expected_q.size() != 0) @(posedge i_clk);
        end

        repeat (10) @(posedge i_clk);

        $display("Sent %0d list operations, checked %0d results over four idling phases.",
                 n_items, n_results);
        $display("Searches hit %0d times, %0d inserts refused when full, %0d deletes when empty.",
                 n_found, n_full, n_empty);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine_unit.sv
bench/tb.sv
